### hdl/abrd_pkg.sv
package abrd_pkg;

  localparam int PROB_BITS       = 11;
  localparam int ADAPT_SHIFT     = 5;
  localparam int MAX_DIRECT_BITS = 26;
  localparam int VALUE_W         = 26;
  localparam int COUNT_W         = 5;
  localparam int BYTE_W          = 8;
  localparam int BASE_W          = 11;
  localparam int CODER_W         = 32;

  localparam logic [PROB_BITS:0]   PROB_ONE  = 12'd2048;
  localparam logic [PROB_BITS-1:0] PROB_INIT = 11'd1024;
  localparam logic [CODER_W-1:0]   TOP_VALUE = 32'h0100_0000;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_TREE    = 2'd2,
    ACT_DIRECT  = 2'd3
  } action_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic restart;
    logic push;
    logic clr_step;
    logic idx_sub;
    logic tree_mul;
    logic tree_bit;
    logic dir_bit;
    logic load_out;
  } abrd_cmd_t;

  typedef struct packed {
    logic    in_fire;
    action_t in_action;
    logic    in_count_zero;
    logic    clr_last;
    logic    idx_ge;
    logic    last_bit;
    logic    out_free;
  } abrd_sts_t;

endpackage

### hdl/abrd_in_if.sv
interface abrd_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [abrd_pkg::BYTE_W-1:0]       in_byte;
  logic [abrd_pkg::BASE_W-1:0]       tree_base;
  logic [abrd_pkg::COUNT_W-1:0]      bit_count;

  modport source (output valid, action, in_byte, tree_base, bit_count, input ready);
  modport sink   (input valid, action, in_byte, tree_base, bit_count, output ready);
endinterface

### hdl/abrd_out_if.sv
interface abrd_out_if;
  logic                          valid;
  logic                          ready;
  logic [abrd_pkg::VALUE_W-1:0]  value;
  logic                          underflow;
  logic                          queue_full;

  modport source (output valid, value, underflow, queue_full, input ready);
  modport sink   (input valid, value, underflow, queue_full, output ready);
endinterface

### hdl/abrd_ctrl.sv
module abrd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  abrd_pkg::abrd_sts_t sts,
  output abrd_pkg::abrd_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PUSH  = 9'b000000100,
    S_RCLR  = 9'b000001000,
    S_TIDX  = 9'b000010000,
    S_TMUL  = 9'b000100000,
    S_TUPD  = 9'b001000000,
    S_DIR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) begin
          cmd.accept = 1'b1;
          case (sts.in_action)
            abrd_pkg::ACT_PUSH: state_next = S_PUSH;
            abrd_pkg::ACT_RESTART: begin
              cmd.restart = 1'b1;
              state_next  = S_RCLR;
            end
            abrd_pkg::ACT_TREE:   state_next = sts.in_count_zero ? S_DONE : S_TIDX;
            abrd_pkg::ACT_DIRECT: state_next = sts.in_count_zero ? S_DONE : S_DIR;
            default:              state_next = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_DONE;
      end
      S_RCLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_DONE;
      end
      S_TIDX: begin
        if (sts.idx_ge) begin
          cmd.idx_sub = 1'b1;
        end else begin
          state_next = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.tree_mul = 1'b1;
        state_next   = S_TUPD;
      end
      S_TUPD: begin
        cmd.tree_bit = 1'b1;
        state_next   = sts.last_bit ? S_DONE : S_TIDX;
      end
      S_DIR: begin
        cmd.dir_bit = 1'b1;
        if (sts.last_bit) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

### hdl/abrd_dpath.sv
module abrd_dpath #(
  parameter int PROB_DEPTH    = 2048,
  parameter int QUEUE_DEPTH   = 32,
  parameter int MAX_TREE_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [abrd_pkg::CODER_W-1:0]         initial_code,
  input  abrd_pkg::abrd_cmd_t                  cmd,
  output abrd_pkg::abrd_sts_t                  sts,
  abrd_in_if.sink                              in_ch,
  abrd_out_if.source                           out_ch
);

  localparam int ADDR_W = $clog2(PROB_DEPTH);
  localparam int SUM_W  = ((ADDR_W > abrd_pkg::BASE_W) ? ADDR_W : abrd_pkg::BASE_W) + 1;
  localparam int QP_W   = $clog2(QUEUE_DEPTH);
  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NODE_W = MAX_TREE_BITS + 1;
  localparam int CW     = abrd_pkg::CODER_W;
  localparam int PB     = abrd_pkg::PROB_BITS;

  logic [PB-1:0]                    prob_mem [PROB_DEPTH];
  logic [abrd_pkg::BYTE_W-1:0]      queue_mem [QUEUE_DEPTH];

  logic [CW-1:0]                    range_q;
  logic [CW-1:0]                    code_q;
  logic [CW-1:0]                    bound;
  logic [PB-1:0]                    prob_rd;
  logic [abrd_pkg::BYTE_W-1:0]      q_rd;
  logic [abrd_pkg::BYTE_W-1:0]      byte_q;
  logic [abrd_pkg::BASE_W-1:0]      base_q;
  logic [abrd_pkg::COUNT_W-1:0]     count;
  logic [NODE_W-1:0]                node;
  logic [SUM_W-1:0]                 idx;
  logic [ADDR_W-1:0]                clr_addr;
  logic [QP_W-1:0]                  rd_ptr;
  logic [QP_W-1:0]                  wr_ptr;
  logic [LVL_W-1:0]                 level;
  logic [abrd_pkg::VALUE_W-1:0]     value_q;
  logic                             under_q;
  logic                             full_q;
  logic                             out_valid;
  logic [abrd_pkg::VALUE_W-1:0]     out_value;
  logic                             out_under;
  logic                             out_full;

  logic [QP_W-1:0]                  rd_ptr_next;
  logic [QP_W-1:0]                  rd_ptr_inc;
  logic [QP_W-1:0]                  wr_ptr_inc;
  logic [CW-1:0]                    r_dir;
  logic [CW-1:0]                    c_dir;
  logic                             dir_ge;
  logic                             tree_lt;
  logic [CW-1:0]                    r_tree;
  logic [CW-1:0]                    c_tree;
  logic [CW-1:0]                    r_pre;
  logic [CW-1:0]                    c_pre;
  logic                             bit_new;
  logic                             need_byte;
  logic                             q_has;
  logic [abrd_pkg::BYTE_W-1:0]      byte_in;
  logic [CW-1:0]                    r_norm;
  logic [CW-1:0]                    c_norm;
  logic                             pop;
  logic                             push_ok;
  logic [PB-1:0]                    prob_next;
  logic [NODE_W-1:0]                node_next;
  logic [abrd_pkg::COUNT_W-1:0]     count_sat;
  logic                             decoding;

  assign in_ch.ready       = cmd.in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.value      = out_value;
  assign out_ch.underflow  = out_under;
  assign out_ch.queue_full = out_full;

  assign sts.in_fire       = in_ch.valid && cmd.in_ready;
  assign sts.in_action     = abrd_pkg::action_t'(in_ch.action);
  assign sts.in_count_zero = (in_ch.bit_count == '0);
  assign sts.clr_last      = (clr_addr == ADDR_W'(PROB_DEPTH - 1));
  assign sts.idx_ge        = (idx >= SUM_W'(PROB_DEPTH));
  assign sts.last_bit      = (count == abrd_pkg::COUNT_W'(1));
  assign sts.out_free      = !out_valid || out_ch.ready;

  always_comb begin
    if (in_ch.action == abrd_pkg::ACT_TREE) begin
      count_sat = (in_ch.bit_count > abrd_pkg::COUNT_W'(MAX_TREE_BITS))
                  ? abrd_pkg::COUNT_W'(MAX_TREE_BITS) : in_ch.bit_count;
    end else begin
      count_sat = (in_ch.bit_count > abrd_pkg::COUNT_W'(abrd_pkg::MAX_DIRECT_BITS))
                  ? abrd_pkg::COUNT_W'(abrd_pkg::MAX_DIRECT_BITS) : in_ch.bit_count;
    end
  end

  assign rd_ptr_inc = (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc = (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;

  always_comb begin
    r_dir     = range_q >> 1;
    dir_ge    = (code_q >= r_dir);
    c_dir     = dir_ge ? code_q - r_dir : code_q;
    tree_lt   = (code_q < bound);
    r_tree    = tree_lt ? bound : range_q - bound;
    c_tree    = tree_lt ? code_q : code_q - bound;
    r_pre     = cmd.dir_bit ? r_dir : r_tree;
    c_pre     = cmd.dir_bit ? c_dir : c_tree;
    bit_new   = cmd.dir_bit ? dir_ge : !tree_lt;
    decoding  = cmd.dir_bit || cmd.tree_bit;
    need_byte = (r_pre < abrd_pkg::TOP_VALUE);
    q_has     = (level != '0);
    byte_in   = q_has ? q_rd : '0;
    r_norm    = need_byte ? {r_pre[CW-9:0], 8'h00} : r_pre;
    c_norm    = need_byte ? {c_pre[CW-9:0], byte_in} : c_pre;
    pop       = decoding && need_byte && q_has;
    push_ok   = cmd.push && (level < LVL_W'(QUEUE_DEPTH));
    rd_ptr_next = pop ? rd_ptr_inc : rd_ptr;
    if (tree_lt) begin
      prob_next = PB'(({1'b0, prob_rd} + ((abrd_pkg::PROB_ONE - {1'b0, prob_rd})
                  >> abrd_pkg::ADAPT_SHIFT)));
    end else begin
      prob_next = prob_rd - (prob_rd >> abrd_pkg::ADAPT_SHIFT);
    end
    node_next = {node[NODE_W-2:0], bit_new};
  end

  // probability store: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      prob_mem[clr_addr] <= abrd_pkg::PROB_INIT;
    end else if (cmd.tree_bit) begin
      prob_mem[idx[ADDR_W-1:0]] <= prob_next;
    end
    prob_rd <= prob_mem[idx[ADDR_W-1:0]];
  end

  // byte queue: read ahead at the pointer that holds after this cycle
  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue_mem[wr_ptr] <= byte_q;
    end
    q_rd <= queue_mem[rd_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_q   <= '1;
      code_q    <= '0;
      clr_addr  <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.restart) begin
        range_q <= '1;
        code_q  <= initial_code;
      end else if (decoding) begin
        range_q <= r_norm;
        code_q  <= c_norm;
      end
      if (cmd.clr_step) begin
        clr_addr <= sts.clr_last ? '0 : clr_addr + 1'b1;
      end
      rd_ptr <= rd_ptr_next;
      if (push_ok) begin
        wr_ptr <= wr_ptr_inc;
        level  <= level + 1'b1;
      end else if (pop) begin
        level  <= level - 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q  <= in_ch.in_byte;
      base_q  <= in_ch.tree_base;
      count   <= count_sat;
      node    <= NODE_W'(1);
      idx     <= SUM_W'(in_ch.tree_base) + SUM_W'(1);
      value_q <= '0;
      under_q <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      if (cmd.push && !push_ok) full_q <= 1'b1;
      if (cmd.idx_sub) idx <= idx - SUM_W'(PROB_DEPTH);
      if (cmd.tree_mul) begin
        bound <= CW'({{(CW-CW+PB){1'b0}}, range_q[CW-1:PB]} * {{(CW-PB){1'b0}}, prob_rd});
      end
      if (decoding) begin
        value_q <= {value_q[abrd_pkg::VALUE_W-2:0], bit_new};
        count   <= count - 1'b1;
        if (need_byte && !q_has) under_q <= 1'b1;
      end
      if (cmd.tree_bit) begin
        node <= node_next;
        idx  <= SUM_W'(base_q) + SUM_W'(node_next);
      end
    end
    if (cmd.load_out) begin
      out_value <= value_q;
      out_under <= under_q;
      out_full  <= full_q;
    end
  end

endmodule

### hdl/adaptive_binary_range_decoder.sv
// Adaptive binary range decoder. Items arrive on in_ch and each gives exactly one result on
// out_ch; a result waits in an output register, so the next item is taken while it is pending,
// but only one item is worked at a time. Push puts the byte into the queue if there is room. A
// tree item works each bit through probability read, multiply, and update with renormalisation,
// with an extra step that takes PROB_DEPTH off the store index each time it is PROB_DEPTH or
// more. A direct item decodes its bits one after another. A restart reloads range and code and
// rewrites every probability, one entry a cycle; the same clearing pass runs after reset, and
// in_ch.ready stays low until it is done. initial_code sits at byte address 0 of the APB port;
// the user must write it only while the block is idle, as the block itself does not enforce it.
module adaptive_binary_range_decoder #(
  parameter int PROB_DEPTH    = 2048,
  parameter int QUEUE_DEPTH   = 32,
  parameter int MAX_TREE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  abrd_in_if.sink     in_ch,
  abrd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  abrd_pkg::abrd_cmd_t cmd;
  abrd_pkg::abrd_sts_t sts;
  logic [abrd_pkg::CODER_W-1:0] initial_code;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : initial_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_code <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      initial_code <= pwdata;
    end
  end

  abrd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  abrd_dpath #(
    .PROB_DEPTH    (PROB_DEPTH),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MAX_TREE_BITS (MAX_TREE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .initial_code (initial_code),
    .cmd          (cmd),
    .sts          (sts),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

endmodule

### hdl/abrd_checker.sv
module abrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [25:0] out_value,
  input logic        out_underflow,
  input logic        out_queue_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_value) && $stable(out_underflow) && $stable(out_queue_full))
    else $error("stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_underflow && out_queue_full))
    else $error("push and decode flags in one result");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item taken before the probability store was cleared");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

bind adaptive_binary_range_decoder abrd_checker u_abrd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.value),
  .out_underflow  (out_ch.underflow),
  .out_queue_full (out_ch.queue_full)
);
